@@ design/handheld_console_memory_bus_assert.svh @@
// assertion macros for the memory bus decoder
// included by modules that carry concurrent checks
`ifndef HANDHELD_CONSOLE_MEMORY_BUS_ASSERT_SVH
`define HANDHELD_CONSOLE_MEMORY_BUS_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define HCMB_ASSERT_IMP(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("hcmb check failed");
`define HCMB_ASSERT_NXT(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("hcmb check failed");
`else
`define HCMB_ASSERT_IMP(label, clk_s, rstn_s, ante, cons)
`define HCMB_ASSERT_NXT(label, clk_s, rstn_s, ante, cons)
`endif
`endif

@@ design/hcmb_pkg.sv @@
// shared types, codes and tables of the memory bus decoder
// no dependencies
package hcmb_pkg;

    localparam int DEF_CART_BYTES  = 32768;
    localparam int DEF_BOOT_BYTES  = 256;
    localparam int DEF_COPY_LENGTH = 160;

    localparam int QUEUE_DEPTH = 2;

    typedef logic [1:0] func_t;
    localparam func_t FUNC_READ      = 2'd0;
    localparam func_t FUNC_WRITE     = 2'd1;
    localparam func_t FUNC_LOAD_CART = 2'd2;
    localparam func_t FUNC_LOAD_BOOT = 2'd3;

    typedef logic [3:0] region_t;
    localparam region_t REG_ROM    = 4'd0;
    localparam region_t REG_VRAM   = 4'd1;
    localparam region_t REG_ERAM   = 4'd2;
    localparam region_t REG_WRAM   = 4'd3;
    localparam region_t REG_OAM    = 4'd4;
    localparam region_t REG_UNUSED = 4'd5;
    localparam region_t REG_IO     = 4'd6;
    localparam region_t REG_HRAM   = 4'd7;
    localparam region_t REG_IE     = 4'd8;

    typedef struct packed {
        func_t       func;
        logic [15:0] addr;
        logic [7:0]  wdata;
        logic [7:0]  keys;
        logic [7:0]  div;
        logic [7:0]  line;
        logic [2:0]  stat;
        region_t     region;
    } item_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_status_t;

    localparam logic [7:0] IO_POWER_ON [128] = '{
        8'hCF, 8'h00, 8'h7E, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hF8,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hE1,
        8'h80, 8'h3F, 8'h00, 8'hFF, 8'hBF, 8'hFF, 8'h3F, 8'h00,
        8'hFF, 8'hBF, 8'h7F, 8'hFF, 8'h9F, 8'hFF, 8'hBF, 8'hFF,
        8'hFF, 8'h00, 8'h00, 8'hBF, 8'h00, 8'h00, 8'h70, 8'hFF,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'h00, 8'h84, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFC,
        8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
    };

    function automatic region_t region_of(input logic [15:0] a);
        region_t r;
        if (a < 16'h8000)
            r = REG_ROM;
        else if (a < 16'hA000)
            r = REG_VRAM;
        else if (a < 16'hC000)
            r = REG_ERAM;
        else if (a < 16'hFE00)
            r = REG_WRAM;
        else if (a < 16'hFEA0)
            r = REG_OAM;
        else if (a < 16'hFF00)
            r = REG_UNUSED;
        else if (a < 16'hFF80)
            r = REG_IO;
        else if (a < 16'hFFFF)
            r = REG_HRAM;
        else
            r = REG_IE;
        return r;
    endfunction

endpackage

@@ design/hcmb_front.sv @@
// front end: unpacks requests, classifies the address region, pushes to the queue
// depends on hcmb_pkg
module hcmb_front
    import hcmb_pkg::*;
(
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        busy,
    input  q_status_t   q_stat,
    output logic        push,
    output item_t       push_item
);

    always_comb
    begin
        push_item.func   = s_tuser;
        push_item.addr   = s_tdata[15:0];
        push_item.wdata  = s_tdata[23:16];
        push_item.keys   = s_tdata[31:24];
        push_item.div    = s_tdata[39:32];
        push_item.line   = s_tdata[47:40];
        push_item.stat   = s_tdata[50:48];
        push_item.region = region_of(s_tdata[15:0]);
    end

    // no requests while the stores are being cleared or the queue is full
    assign s_tready = !q_stat.full && !busy;
    assign push     = s_tvalid && s_tready;

endmodule

@@ design/hcmb_queue.sv @@
// two-entry request queue between front and back end
// depends on hcmb_pkg
module hcmb_queue
    import hcmb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  item_t     push_item,
    input  logic      pop,
    output item_t     head,
    output q_status_t q_stat
);

    item_t      entry_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    assign head         = entry_reg[rd_ptr_reg];
    assign q_stat.valid = count_reg != 2'd0;
    assign q_stat.full  = count_reg == 2'(QUEUE_DEPTH);

endmodule

@@ design/hcmb_back.sv @@
// back end: stores, register file, oam copy sequencer, clearing sweep, result register
// depends on hcmb_pkg and the assertion macro header
`include "handheld_console_memory_bus_assert.svh"
module hcmb_back
    import hcmb_pkg::*;
#(
    parameter int CART_BYTES  = DEF_CART_BYTES,
    parameter int BOOT_BYTES  = DEF_BOOT_BYTES,
    parameter int COPY_LENGTH = DEF_COPY_LENGTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  q_status_t   q_stat,
    input  item_t       head,
    output logic        pop,
    output logic        busy,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata
);

    localparam int CART_AW = $clog2(CART_BYTES);
    localparam int BOOT_AW = (BOOT_BYTES > 1) ? $clog2(BOOT_BYTES) : 1;
    localparam int CLR_LEN = (CART_BYTES > 8192) ? CART_BYTES : 8192;
    localparam int CLR_W   = $clog2(CLR_LEN);

    localparam logic [2:0] ST_CLEAR   = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_RDATA   = 3'd2;
    localparam logic [2:0] ST_COPY_RD = 3'd3;
    localparam logic [2:0] ST_COPY_WR = 3'd4;

    localparam logic [6:0] IO_JOYP = 7'h00;
    localparam logic [6:0] IO_DIV  = 7'h04;
    localparam logic [6:0] IO_IF   = 7'h0F;
    localparam logic [6:0] IO_STAT = 7'h41;
    localparam logic [6:0] IO_LY   = 7'h44;
    localparam logic [6:0] IO_DMA  = 7'h46;
    localparam logic [6:0] IO_KEY1 = 7'h4D;
    localparam logic [6:0] IO_BOOT = 7'h50;

    logic [2:0]       st_reg, st_next;
    logic [CLR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [7:0]       copy_cnt_reg, copy_cnt_next;
    logic             boot_mapped_reg, boot_mapped_next;
    logic [4:0]       status_upper_reg, status_upper_next;
    logic [7:0]       irq_enable_reg, irq_enable_next;
    item_t            cur_reg;

    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_rd_reg;
    logic             out_tile_reg;
    logic [12:0]      out_toff_reg;
    logic             out_dres_reg;
    logic             out_load, out_tile, out_dres;
    logic [7:0]       out_rd;
    logic [12:0]      out_toff;
    logic             out_free, is_dma, in_copy;

    // read path
    logic [15:0]      rd_addr;
    region_t          rd_region, rd_region_reg;
    logic [6:0]       rd_low_reg;
    logic             rd_boot_hit_reg, rd_cart_hit_reg;
    logic [7:0]       rd_value;

    logic [7:0] cart_mem [CART_BYTES];
    logic [7:0] boot_mem [BOOT_BYTES];
    logic [7:0] vram_mem [8192];
    logic [7:0] eram_mem [8192];
    logic [7:0] wram_mem [8192];
    logic [7:0] spr_mem  [160];
    logic [7:0] io_mem   [128];
    logic [7:0] hram_mem [127];
    logic [7:0] cart_q, boot_q, vram_q, eram_q, wram_q, spr_q, io_q, hram_q;

    logic               cart_we, boot_we, vram_we, eram_we, wram_we, spr_we, io_we, hram_we;
    logic [CART_AW-1:0] cart_wa;
    logic [BOOT_AW-1:0] boot_wa;
    logic [12:0]        big_wa;
    logic [7:0]         spr_wa;
    logic [6:0]         small_wa;
    logic [7:0]         cart_wd, boot_wd, big_wd, spr_wd, io_wd, hram_wd;

    assign out_free = !out_valid_reg || m_tready;
    assign pop      = (st_reg == ST_IDLE) && q_stat.valid && out_free;
    assign busy     = st_reg == ST_CLEAR;
    assign is_dma   = (head.func == FUNC_WRITE) && (head.region == REG_IO)
                      && (head.addr[6:0] == IO_DMA);
    assign in_copy  = (st_reg == ST_COPY_RD) || (st_reg == ST_COPY_WR);

    assign rd_addr   = (st_reg == ST_COPY_RD) ? {cur_reg.wdata, copy_cnt_reg} : head.addr;
    assign rd_region = (st_reg == ST_COPY_RD) ? region_of(rd_addr) : head.region;

    always_ff @(posedge clk)
    begin
        rd_region_reg   <= rd_region;
        rd_low_reg      <= rd_addr[6:0];
        rd_boot_hit_reg <= boot_mapped_reg && (rd_addr < BOOT_BYTES);
        rd_cart_hit_reg <= rd_addr < CART_BYTES;
    end

    // value seen on the bus for the address issued in the previous cycle
    always_comb
    begin
        case (rd_region_reg)
            REG_ROM:
                rd_value = rd_boot_hit_reg ? boot_q : (rd_cart_hit_reg ? cart_q : 8'hFF);
            REG_VRAM:   rd_value = vram_q;
            REG_ERAM:   rd_value = eram_q;
            REG_WRAM:   rd_value = wram_q;
            REG_OAM:    rd_value = spr_q;
            REG_UNUSED: rd_value = 8'hFF;
            REG_IO:
            begin
                case (rd_low_reg)
                    IO_JOYP:
                    begin
                        if (!io_q[4])
                            rd_value = 8'hC0 | io_q | {4'h0, cur_reg.keys[3:0]};
                        else if (!io_q[5])
                            rd_value = 8'hC0 | io_q | {4'h0, cur_reg.keys[7:4]};
                        else
                            rd_value = 8'hFF;
                    end
                    IO_DIV:  rd_value = cur_reg.div;
                    IO_IF:   rd_value = io_q | 8'hE0;
                    IO_STAT: rd_value = {status_upper_reg, cur_reg.stat};
                    IO_LY:   rd_value = cur_reg.line;
                    IO_KEY1: rd_value = 8'hFF;
                    IO_BOOT: rd_value = 8'hFF;
                    default: rd_value = io_q;
                endcase
            end
            REG_HRAM:   rd_value = hram_q;
            default:    rd_value = irq_enable_reg;
        endcase
    end

    always_comb
    begin
        st_next           = st_reg;
        clr_cnt_next      = clr_cnt_reg;
        copy_cnt_next     = copy_cnt_reg;
        boot_mapped_next  = boot_mapped_reg;
        status_upper_next = status_upper_reg;
        irq_enable_next   = irq_enable_reg;
        out_load = 1'b0;
        out_rd   = 8'h00;
        out_tile = 1'b0;
        out_toff = 13'h0;
        out_dres = 1'b0;
        cart_we = 1'b0;
        boot_we = 1'b0;
        vram_we = 1'b0;
        eram_we = 1'b0;
        wram_we = 1'b0;
        spr_we  = 1'b0;
        io_we   = 1'b0;
        hram_we = 1'b0;
        cart_wa  = head.addr[CART_AW-1:0];
        boot_wa  = head.addr[BOOT_AW-1:0];
        big_wa   = head.addr[12:0];
        spr_wa   = head.addr[7:0];
        small_wa = head.addr[6:0];
        cart_wd = head.wdata;
        boot_wd = head.wdata;
        big_wd  = head.wdata;
        spr_wd  = head.wdata;
        io_wd   = head.wdata;
        hram_wd = head.wdata;
        case (st_reg)
            ST_CLEAR:
            begin
                cart_we  = clr_cnt_reg < CART_BYTES;
                boot_we  = clr_cnt_reg < BOOT_BYTES;
                vram_we  = clr_cnt_reg < 8192;
                eram_we  = clr_cnt_reg < 8192;
                wram_we  = clr_cnt_reg < 8192;
                spr_we   = clr_cnt_reg < 160;
                io_we    = clr_cnt_reg < 128;
                hram_we  = clr_cnt_reg < 127;
                cart_wa  = clr_cnt_reg[CART_AW-1:0];
                boot_wa  = clr_cnt_reg[BOOT_AW-1:0];
                big_wa   = clr_cnt_reg[12:0];
                spr_wa   = clr_cnt_reg[7:0];
                small_wa = clr_cnt_reg[6:0];
                cart_wd  = 8'h00;
                boot_wd  = 8'h00;
                big_wd   = 8'h00;
                spr_wd   = 8'h00;
                io_wd    = IO_POWER_ON[clr_cnt_reg[6:0]];
                hram_wd  = 8'h00;
                if (clr_cnt_reg == CLR_W'(CLR_LEN - 1))
                    st_next = ST_IDLE;
                else
                    clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (pop)
                begin
                    case (head.func)
                        FUNC_READ:
                            st_next = ST_RDATA;
                        FUNC_LOAD_CART:
                        begin
                            cart_we  = head.addr < CART_BYTES;
                            out_load = 1'b1;
                        end
                        FUNC_LOAD_BOOT:
                        begin
                            boot_we  = head.addr < BOOT_BYTES;
                            out_load = 1'b1;
                        end
                        default:
                        begin
                            out_load = 1'b1;
                            case (head.region)
                                REG_VRAM:
                                begin
                                    vram_we = 1'b1;
                                    if (head.addr < 16'h9800)
                                    begin
                                        out_tile = 1'b1;
                                        out_toff = head.addr[12:0];
                                    end
                                end
                                REG_ERAM: eram_we = 1'b1;
                                REG_WRAM: wram_we = 1'b1;
                                REG_OAM:  spr_we  = 1'b1;
                                REG_IO:
                                begin
                                    io_we = 1'b1;
                                    case (head.addr[6:0])
                                        IO_DIV:  out_dres = 1'b1;
                                        IO_STAT: status_upper_next = head.wdata[7:3];
                                        IO_DMA:
                                        begin
                                            out_load      = 1'b0;
                                            copy_cnt_next = 8'h00;
                                            st_next       = ST_COPY_RD;
                                        end
                                        IO_BOOT:
                                        begin
                                            if (head.wdata != 8'h00)
                                                boot_mapped_next = 1'b0;
                                        end
                                        default: ;
                                    endcase
                                end
                                REG_HRAM: hram_we = 1'b1;
                                REG_IE:   irq_enable_next = head.wdata;
                                default: ;
                            endcase
                        end
                    endcase
                end
            end
            ST_RDATA:
            begin
                out_load = 1'b1;
                out_rd   = rd_value;
                st_next  = ST_IDLE;
            end
            ST_COPY_RD:
                st_next = ST_COPY_WR;
            ST_COPY_WR:
            begin
                spr_we = 1'b1;
                spr_wa = copy_cnt_reg;
                spr_wd = rd_value;
                if (copy_cnt_reg == 8'(COPY_LENGTH - 1))
                begin
                    out_load = 1'b1;
                    st_next  = ST_IDLE;
                end
                else
                begin
                    copy_cnt_next = copy_cnt_reg + 8'd1;
                    st_next       = ST_COPY_RD;
                end
            end
            default:
                st_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg           <= ST_CLEAR;
            clr_cnt_reg      <= '0;
            copy_cnt_reg     <= 8'h00;
            boot_mapped_reg  <= 1'b1;
            status_upper_reg <= 5'h10;
            irq_enable_reg   <= 8'h00;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            st_reg           <= st_next;
            clr_cnt_reg      <= clr_cnt_next;
            copy_cnt_reg     <= copy_cnt_next;
            boot_mapped_reg  <= boot_mapped_next;
            status_upper_reg <= status_upper_next;
            irq_enable_reg   <= irq_enable_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= head;
        if (out_load)
        begin
            out_rd_reg   <= out_rd;
            out_tile_reg <= out_tile;
            out_toff_reg <= out_toff;
            out_dres_reg <= out_dres;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cart_we)
            cart_mem[cart_wa] <= cart_wd;
        cart_q <= cart_mem[rd_addr[CART_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (boot_we)
            boot_mem[boot_wa] <= boot_wd;
        boot_q <= boot_mem[rd_addr[BOOT_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (vram_we)
            vram_mem[big_wa] <= big_wd;
        vram_q <= vram_mem[rd_addr[12:0]];
    end

    always_ff @(posedge clk)
    begin
        if (eram_we)
            eram_mem[big_wa] <= big_wd;
        eram_q <= eram_mem[rd_addr[12:0]];
    end

    always_ff @(posedge clk)
    begin
        if (wram_we)
            wram_mem[big_wa] <= big_wd;
        wram_q <= wram_mem[rd_addr[12:0]];
    end

    always_ff @(posedge clk)
    begin
        if (spr_we)
            spr_mem[spr_wa] <= spr_wd;
        spr_q <= spr_mem[rd_addr[7:0]];
    end

    always_ff @(posedge clk)
    begin
        if (io_we)
            io_mem[small_wa] <= io_wd;
        io_q <= io_mem[rd_addr[6:0]];
    end

    always_ff @(posedge clk)
    begin
        if (hram_we)
            hram_mem[small_wa] <= hram_wd;
        hram_q <= hram_mem[rd_addr[6:0]];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_dres_reg, out_toff_reg, out_tile_reg, out_rd_reg};

    `HCMB_ASSERT_IMP(a_rdata_out_empty, clk, rst_n, st_reg == ST_RDATA, !out_valid_reg)
    `HCMB_ASSERT_IMP(a_copy_in_range, clk, rst_n, in_copy, copy_cnt_reg < COPY_LENGTH)
    `HCMB_ASSERT_NXT(a_write_result, clk, rst_n, pop && (head.func != FUNC_READ) && !is_dma, out_valid_reg)

endmodule

@@ design/handheld_console_memory_bus.sv @@
// reads pass queue, ST_RDATA and result register; writes and loads pass queue and result register
// a write of the oam copy register gives its result once the sequencer has copied COPY_LENGTH bytes
// after reset the stores are swept clear over max(CART_BYTES, 8192) addresses, with s_tready low
// async active-low reset; io registers come up at their power-on values
// holds front end, request queue and back end; depends on hcmb_pkg
module handheld_console_memory_bus
    import hcmb_pkg::*;
#(
    parameter int CART_BYTES  = DEF_CART_BYTES,
    parameter int BOOT_BYTES  = DEF_BOOT_BYTES,
    parameter int COPY_LENGTH = DEF_COPY_LENGTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // address, write_data, key_state, divider_value, current_line, lcd_status_low
    input  logic [55:0] s_tdata,
    // func
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_data, tile_update, tile_offset, divider_reset
    output logic [23:0] m_tdata
);

    q_status_t q_stat;
    item_t     push_item, head;
    logic      push, pop, busy;

    hcmb_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .busy      (busy),
        .q_stat    (q_stat),
        .push      (push),
        .push_item (push_item)
    );

    hcmb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    hcmb_back #(
        .CART_BYTES  (CART_BYTES),
        .BOOT_BYTES  (BOOT_BYTES),
        .COPY_LENGTH (COPY_LENGTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .head     (head),
        .pop      (pop),
        .busy     (busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
